// ===== rtl/core/pime_pkg.sv =====
package pime_pkg;

    localparam int PARTITIONS    = 8;
    localparam int DIMENSIONS    = 8;
    localparam int VALUE_BITS    = 20;

    localparam int SUM_W         = 32;
    localparam int OUT_W         = 31;
    localparam int PART_FIELD_W  = 3;
    localparam int DIM_FIELD_W   = 3;
    localparam int VALUE_FIELD_W = 20;
    localparam int DIM_AW        = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1;
    localparam int ROW_W         = PARTITIONS * SUM_W;
    localparam int TREE_LEVELS   = $clog2(PARTITIONS);
    localparam int TREE_SIZE     = 1 << TREE_LEVELS;

    localparam logic [SUM_W-1:0] VALUE_MASK = SUM_W'((64'd1 << VALUE_BITS) - 64'd1);

    typedef logic [SUM_W-1:0] sum_t;
    typedef logic [PARTITIONS-1:0][SUM_W-1:0] row_t;

    typedef enum logic [2:0] {
        OP_CLEAR       = 3'd0,
        OP_ADD         = 3'd1,
        OP_EVAL_MOVE   = 3'd2,
        OP_COMMIT_MOVE = 3'd3,
        OP_EVAL_SWAP   = 3'd4,
        OP_COMMIT_SWAP = 3'd5,
        OP_EVAL_ROT    = 3'd6,
        OP_COMMIT_ROT  = 3'd7
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_ADJUST = 4'b0010,
        ST_REDUCE = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    // Per-item adjustment: up to three partitions, each with a wrapped delta.
    typedef struct packed {
        logic [PART_FIELD_W-1:0] part_a;
        logic [PART_FIELD_W-1:0] part_b;
        logic [PART_FIELD_W-1:0] part_c;
        logic                    en_a;
        logic                    en_b;
        logic                    en_c;
        sum_t                    delta_a;
        sum_t                    delta_b;
        sum_t                    delta_c;
    } adj_t;

endpackage

// ===== rtl/core/pime_ram.sv =====
module pime_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                    aclk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/pime_row_update.sv =====
module pime_row_update (
    input  pime_pkg::row_t row_in,
    input  pime_pkg::adj_t adj,
    output pime_pkg::row_t row_out
);

    // Each lane adds every delta aimed at it; coinciding targets accumulate.
    always_comb begin
        for (int p = 0; p < pime_pkg::PARTITIONS; p++) begin
            row_out[p] = row_in[p]
                + ((adj.en_a && int'(adj.part_a) == p) ? adj.delta_a : '0)
                + ((adj.en_b && int'(adj.part_b) == p) ? adj.delta_b : '0)
                + ((adj.en_c && int'(adj.part_c) == p) ? adj.delta_c : '0);
        end
    end

endmodule

// ===== rtl/core/pime_spread.sv =====
module pime_spread (
    input  pime_pkg::row_t row_in,
    output pime_pkg::sum_t hi,
    output pime_pkg::sum_t lo
);

    logic signed [pime_pkg::SUM_W-1:0] hi_t [pime_pkg::TREE_SIZE];
    logic signed [pime_pkg::SUM_W-1:0] lo_t [pime_pkg::TREE_SIZE];

    // Pairwise signed min/max tree; pad unused leaves with lane zero.
    always_comb begin
        for (int i = 0; i < pime_pkg::TREE_SIZE; i++) begin
            hi_t[i] = (i < pime_pkg::PARTITIONS) ? row_in[i] : row_in[0];
            lo_t[i] = hi_t[i];
        end
        for (int lv = 0; lv < pime_pkg::TREE_LEVELS; lv++) begin
            for (int i = 0; i < (pime_pkg::TREE_SIZE >> (lv + 1)); i++) begin
                hi_t[i] = (hi_t[2*i] > hi_t[2*i+1]) ? hi_t[2*i] : hi_t[2*i+1];
                lo_t[i] = (lo_t[2*i] < lo_t[2*i+1]) ? lo_t[2*i] : lo_t[2*i+1];
            end
        end
        hi = hi_t[0];
        lo = lo_t[0];
    end

endmodule

// ===== rtl/core/partition_imbalance_move_evaluator.sv =====
// Partition imbalance move evaluator.
// Input channel (s_*): one word per item. s_tuser carries the operation,
// s_tlast marks the last dimension of an evaluation, s_tdata the dimension,
// the three partition indexes and the three element values.
// Result channel (m_*): one word holding the imbalance, sent only for an
// evaluate or commit word with s_tlast set.
// The partition sums sit in a row-wide RAM, one row per dimension, read
// through a registered port; a per-row valid bit makes an unwritten or
// cleared row read as zero.
// Sequencing: a clear is done when accepted, an add reads and then adjusts
// and writes back, an evaluate or commit reads, adjusts (writing back only
// for a commit), runs the min/max tree, then computes the spread and folds
// it. One item is in work at a time; s_tready is high only between items.
// Reset: all rows read as zero, running maximum is zero, no result pending.
// Stall: the result sits in an output register; a new item is accepted while
// it waits, and an item that must emit a further result holds in its final
// step until the output register is free.
module partition_imbalance_move_evaluator (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    // [2:0] dimension, [5:3] part_a, [8:6] part_b, [11:9] part_c,
    // [31:12] value_a, [51:32] value_b, [71:52] value_c
    input  logic [71:0] s_tdata,
    // [2:0] operation
    input  logic [2:0]  s_tuser,
    input  logic        s_tlast,

    output logic        m_tvalid,
    input  logic        m_tready,
    // [30:0] imbalance, [31] zero
    output logic [31:0] m_tdata
);

    // Unpack the input word.
    pime_pkg::op_t                         in_op;
    logic [pime_pkg::DIM_FIELD_W-1:0]      in_dim;
    logic [pime_pkg::PART_FIELD_W-1:0]     in_pa, in_pb, in_pc;
    pime_pkg::sum_t                        in_va, in_vb, in_vc;
    logic                                  in_dim_ok;
    logic [pime_pkg::DIM_AW-1:0]           in_addr;
    logic                                  accept;
    pime_pkg::adj_t                        in_adj;
    logic                                  in_write;

    assign in_op     = pime_pkg::op_t'(s_tuser);
    assign in_dim    = s_tdata[2:0];
    assign in_pa     = s_tdata[5:3];
    assign in_pb     = s_tdata[8:6];
    assign in_pc     = s_tdata[11:9];
    assign in_va     = pime_pkg::SUM_W'(s_tdata[31:12]) & pime_pkg::VALUE_MASK;
    assign in_vb     = pime_pkg::SUM_W'(s_tdata[51:32]) & pime_pkg::VALUE_MASK;
    assign in_vc     = pime_pkg::SUM_W'(s_tdata[71:52]) & pime_pkg::VALUE_MASK;
    assign in_dim_ok = int'(in_dim) < pime_pkg::DIMENSIONS;
    assign in_addr   = pime_pkg::DIM_AW'(in_dim);
    assign accept    = s_tvalid && s_tready;

    // Turn the operation into up to three (partition, delta) adjustments.
    always_comb begin
        in_adj.part_a  = in_pa;
        in_adj.part_b  = in_pb;
        in_adj.part_c  = in_pc;
        in_adj.en_a    = 1'b0;
        in_adj.en_b    = 1'b0;
        in_adj.en_c    = 1'b0;
        in_adj.delta_a = '0;
        in_adj.delta_b = '0;
        in_adj.delta_c = '0;
        in_write       = 1'b0;
        unique case (in_op) inside
            pime_pkg::OP_ADD: begin
                in_adj.en_a    = 1'b1;
                in_adj.delta_a = in_va;
                in_write       = 1'b1;
            end
            pime_pkg::OP_EVAL_MOVE, pime_pkg::OP_COMMIT_MOVE: begin
                in_adj.en_a    = 1'b1;
                in_adj.en_b    = 1'b1;
                in_adj.delta_a = '0 - in_va;
                in_adj.delta_b = in_va;
                in_write       = (in_op == pime_pkg::OP_COMMIT_MOVE);
            end
            pime_pkg::OP_EVAL_SWAP, pime_pkg::OP_COMMIT_SWAP: begin
                in_adj.en_a    = 1'b1;
                in_adj.en_b    = 1'b1;
                in_adj.delta_a = in_vb - in_va;
                in_adj.delta_b = in_va - in_vb;
                in_write       = (in_op == pime_pkg::OP_COMMIT_SWAP);
            end
            pime_pkg::OP_EVAL_ROT, pime_pkg::OP_COMMIT_ROT: begin
                in_adj.en_a    = 1'b1;
                in_adj.en_b    = 1'b1;
                in_adj.en_c    = 1'b1;
                in_adj.delta_a = in_vc - in_va;
                in_adj.delta_b = in_va - in_vb;
                in_adj.delta_c = in_vb - in_vc;
                in_write       = (in_op == pime_pkg::OP_COMMIT_ROT);
            end
            default: begin
                in_write = 1'b0;
            end
        endcase
    end

    // Control and item registers.
    pime_pkg::state_t               state_reg, state_next;
    logic [pime_pkg::DIMENSIONS-1:0] row_valid_reg;
    logic                           rd_valid_reg;
    logic [pime_pkg::DIM_AW-1:0]    addr_reg;
    logic                           dim_ok_reg;
    logic                           write_reg;
    logic                           last_reg;
    logic                           add_reg;
    pime_pkg::adj_t                 adj_reg;
    pime_pkg::row_t                 row_reg;
    pime_pkg::sum_t                 hi_reg, lo_reg;
    logic [pime_pkg::OUT_W-1:0]     max_reg;
    logic                           m_valid_reg;
    logic [pime_pkg::OUT_W-1:0]     m_data_reg;

    // Row memory.
    logic [pime_pkg::ROW_W-1:0] rd_data;
    pime_pkg::row_t             row_in, row_new;
    logic                       ram_we;

    assign ram_we = (state_reg == pime_pkg::ST_ADJUST) && dim_ok_reg && write_reg;

    pime_ram #(
        .WIDTH (pime_pkg::ROW_W),
        .DEPTH (pime_pkg::DIMENSIONS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (addr_reg),
        .wdata (row_new),
        .raddr (in_addr),
        .rdata (rd_data)
    );

    // A row never written since reset or clear reads as zero.
    assign row_in = rd_valid_reg ? pime_pkg::row_t'(rd_data) : '0;

    pime_row_update u_update (
        .row_in  (row_in),
        .adj     (adj_reg),
        .row_out (row_new)
    );

    pime_pkg::sum_t tree_hi, tree_lo;

    pime_spread u_spread (
        .row_in (row_reg),
        .hi     (tree_hi),
        .lo     (tree_lo)
    );

    // Spread with saturation; an out-of-range dimension counts as zero.
    // hi is never below lo, so the difference fits in SUM_W unsigned bits.
    logic [pime_pkg::SUM_W-1:0] diff;
    logic [pime_pkg::OUT_W-1:0] spread;
    logic [pime_pkg::OUT_W-1:0] folded;
    logic                       emit_ok;

    assign diff    = hi_reg - lo_reg;
    assign spread  = !dim_ok_reg ? '0 :
                     diff[pime_pkg::SUM_W-1] ? '1 : diff[pime_pkg::OUT_W-1:0];
    assign folded  = (spread > max_reg) ? spread : max_reg;
    assign emit_ok = !m_valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            pime_pkg::ST_IDLE: begin
                if (accept && in_op != pime_pkg::OP_CLEAR) begin
                    state_next = pime_pkg::ST_ADJUST;
                end
            end
            pime_pkg::ST_ADJUST: begin
                state_next = add_reg ? pime_pkg::ST_IDLE : pime_pkg::ST_REDUCE;
            end
            pime_pkg::ST_REDUCE: begin
                state_next = pime_pkg::ST_FINISH;
            end
            pime_pkg::ST_FINISH: begin
                if (!last_reg || emit_ok) begin
                    state_next = pime_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pime_pkg::ST_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == pime_pkg::ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= pime_pkg::ST_IDLE;
            row_valid_reg <= '0;
            max_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            // Drop a cleared row by its valid bit; mark a written row valid.
            if (accept && in_op == pime_pkg::OP_CLEAR && in_dim_ok) begin
                row_valid_reg[in_addr] <= 1'b0;
            end
            if (ram_we) begin
                row_valid_reg[addr_reg] <= 1'b1;
            end
            // Load a new result, or drop the taken one.
            if (state_reg == pime_pkg::ST_FINISH && last_reg && emit_ok) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (state_reg == pime_pkg::ST_FINISH) begin
                if (!last_reg) begin
                    max_reg <= folded;
                end else if (emit_ok) begin
                    max_reg <= '0;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_valid_reg <= row_valid_reg[in_addr];
            addr_reg     <= in_addr;
            dim_ok_reg   <= in_dim_ok;
            write_reg    <= in_write;
            last_reg     <= s_tlast;
            add_reg      <= (in_op == pime_pkg::OP_ADD);
            adj_reg      <= in_adj;
        end
        if (state_reg == pime_pkg::ST_ADJUST) begin
            row_reg <= row_new;
        end
        if (state_reg == pime_pkg::ST_REDUCE) begin
            hi_reg <= tree_hi;
            lo_reg <= tree_lo;
        end
        if (state_reg == pime_pkg::ST_FINISH && last_reg && emit_ok) begin
            m_data_reg <= folded;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_data_reg};

endmodule

// ===== rtl/core/pime_checker.sv =====
module pime_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [2:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // Hold a stalled result.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Imbalance is saturated to 31 bits.
    a_out_msb: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !m_tdata[31])
        else $error("result top bit set");

    // No result straight out of reset.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A clear never creates a result.
    a_clear_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == pime_pkg::OP_CLEAR && !m_tvalid |=> !m_tvalid)
        else $error("result after clear");

    // Any other word leaves the block busy in the cycle after it is accepted.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser != pime_pkg::OP_CLEAR |=> !s_tready)
        else $error("ready right after a read-modify-write word");

endmodule

bind partition_imbalance_move_evaluator pime_checker u_pime_checker (.*);
